// ----- sv/vtpd_pkg.sv -----
// Shared types, constants and helper functions for the vertex transform core.
`default_nettype none
package vtpd_pkg;

  localparam int unsigned CoordW   = 32;
  localparam int unsigned CoefW    = 16;
  localparam int unsigned ProdW    = CoordW + CoefW;
  localparam int unsigned SumW     = ProdW + 2;
  localparam int unsigned FracShift = 12;
  localparam int unsigned NumW     = CoordW + 16;
  localparam int unsigned DivSteps = NumW;
  localparam int unsigned RowW     = 4 * CoefW;
  localparam int unsigned CfgIdxW  = 2;

  localparam logic [RowW-1:0] Row0Reset = 64'h0000_0000_0000_1000;
  localparam logic [RowW-1:0] Row1Reset = 64'h0000_0000_1000_0000;
  localparam logic [RowW-1:0] Row2Reset = 64'h0000_1000_0000_0000;
  localparam logic [RowW-1:0] Row3Reset = 64'h1000_0000_0000_0000;

  // One lane of the restoring divider: partial remainder and the shift
  // register that holds the remaining dividend bits and the quotient bits.
  typedef struct packed {
    logic [CoordW-1:0] rem;
    logic [NumW-1:0]   nq;
  } div_lane_t;

  typedef struct packed {
    logic [CoordW-1:0] dvs;
    logic              wz;
    logic [CoordW-1:0] wclip;
    logic [2:0]        neg;
    div_lane_t [2:0]   lane;
  } div_stage_t;

  function automatic div_lane_t div_step(div_lane_t a, logic [CoordW-1:0] d);
    logic [CoordW:0] t;
    div_lane_t r;
    begin
      t = {a.rem, a.nq[NumW-1]};
      if (t >= {1'b0, d}) begin
        t    = t - {1'b0, d};
        r.nq = {a.nq[NumW-2:0], 1'b1};
      end else begin
        r.nq = {a.nq[NumW-2:0], 1'b0};
      end
      r.rem = t[CoordW-1:0];
      return r;
    end
  endfunction

  // Round half up from Q22.28 to Q16.16 and saturate to 32 bits.
  function automatic logic signed [CoordW-1:0] round_sat(logic signed [SumW-1:0] s);
    logic signed [SumW-1:0] t;
    logic signed [SumW-FracShift-1:0] r;
    begin
      t = s + SumW'(1 << (FracShift - 1));
      r = (SumW-FracShift)'(t >>> FracShift);
      if (r > (SumW-FracShift)'(signed'(32'sh7fff_ffff))) begin
        return 32'sh7fff_ffff;
      end else if (r < (SumW-FracShift)'(signed'(32'sh8000_0000))) begin
        return 32'sh8000_0000;
      end else begin
        return r[CoordW-1:0];
      end
    end
  endfunction

  // Apply the sign to a quotient magnitude and saturate to 32 bits.
  function automatic logic [CoordW-1:0] quo_sat(logic [NumW-1:0] q, logic neg);
    begin
      if (neg) begin
        if (q > NumW'(33'h1_0000_0000 >> 1)) begin
          return 32'h8000_0000;
        end else begin
          return -q[CoordW-1:0];
        end
      end else if (q > NumW'(32'h7fff_ffff)) begin
        return 32'h7fff_ffff;
      end else begin
        return q[CoordW-1:0];
      end
    end
  endfunction

endpackage
`default_nettype wire

// ----- sv/vertex_transform_perspective_divide_core.sv -----
// Pipelined 4x4 vertex transform followed by a perspective divide.
//
//   port group   dir  contents
//   s_axis       in   tdata: x_in, y_in, z_in, w_in (32 bits each)
//   m_axis       out  tdata: x_ndc, y_ndc, z_ndc, w_clip; tuser: w_zero
//   cfg          in   matrix row writes, index 0..3
//
// One vertex enters per clock while the pipeline advances. The stages are
// multiply, sum, round, divider setup, 48 one-bit restoring divider stages, and the output register.
// The whole pipeline advances together when the output register is empty or
// its transfer completes; a stall freezes every stage. Reset clears valid bits
// and loads the identity matrix.
`default_nettype none
module vertex_transform_perspective_divide_core (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // x_in [31:0], y_in [63:32], z_in [95:64], w_in [127:96]
  input  wire logic [127:0]              s_axis_tdata_i,
  output logic                           m_axis_tvalid_o,
  input  wire logic                      m_axis_tready_i,
  // x_ndc [31:0], y_ndc [63:32], z_ndc [95:64], w_clip [127:96]
  output logic [127:0]                   m_axis_tdata_o,
  // w_zero [0]
  output logic                           m_axis_tuser_o,
  input  wire logic                      cfg_we_i,
  input  wire logic [vtpd_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [vtpd_pkg::RowW-1:0] cfg_data_i
);
  import vtpd_pkg::*;

  localparam int unsigned NStg = 4 + DivSteps + 1;

  logic [RowW-1:0] row_q [4];
  logic [NStg-1:0] vld_q;
  logic            adv;

  logic signed [ProdW-1:0]  prod_q [4][4];
  logic signed [SumW-1:0]   sum_q  [4];
  logic signed [CoordW-1:0] clip_q [4];
  div_stage_t               setup_q;
  div_stage_t               div_q [DivSteps];
  logic [127:0]             out_data_q;
  logic                     out_wz_q;

  assign adv             = !vld_q[NStg-1] || m_axis_tready_i;
  assign s_axis_tready_o = adv;
  assign m_axis_tvalid_o = vld_q[NStg-1];
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_wz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q[0] <= Row0Reset;
      row_q[1] <= Row1Reset;
      row_q[2] <= Row2Reset;
      row_q[3] <= Row3Reset;
    end else if (cfg_we_i) begin
      row_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NStg-2:0], s_axis_tvalid_i};
    end
  end

  // Products: row k weights input component k, column i feeds clip i.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < 4; k++) begin
        for (int i = 0; i < 4; i++) begin
          prod_q[k][i] <= $signed(row_q[k][CoefW*i +: CoefW])
                        * $signed(s_axis_tdata_i[CoordW*k +: CoordW]);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 4; i++) begin
        sum_q[i] <= SumW'(prod_q[0][i]) + SumW'(prod_q[1][i])
                  + SumW'(prod_q[2][i]) + SumW'(prod_q[3][i]);
        clip_q[i] <= round_sat(sum_q[i]);
      end
    end
  end

  // Divider setup: magnitudes, quotient signs and the zero-w flag.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      setup_q.dvs   <= clip_q[3][CoordW-1] ? -clip_q[3] : clip_q[3];
      setup_q.wz    <= (clip_q[3] == '0);
      setup_q.wclip <= clip_q[3];
      for (int l = 0; l < 3; l++) begin
        setup_q.neg[l]      <= clip_q[l][CoordW-1] ^ clip_q[3][CoordW-1];
        setup_q.lane[l].rem <= '0;
        setup_q.lane[l].nq  <= {(clip_q[l][CoordW-1] ? -clip_q[l] : clip_q[l]),
                                16'h0000};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      div_q[0].dvs   <= setup_q.dvs;
      div_q[0].wz    <= setup_q.wz;
      div_q[0].wclip <= setup_q.wclip;
      div_q[0].neg   <= setup_q.neg;
      for (int l = 0; l < 3; l++) begin
        div_q[0].lane[l] <= div_step(setup_q.lane[l], setup_q.dvs);
      end
      for (int j = 1; j < DivSteps; j++) begin
        div_q[j].dvs   <= div_q[j-1].dvs;
        div_q[j].wz    <= div_q[j-1].wz;
        div_q[j].wclip <= div_q[j-1].wclip;
        div_q[j].neg   <= div_q[j-1].neg;
        for (int l = 0; l < 3; l++) begin
          div_q[j].lane[l] <= div_step(div_q[j-1].lane[l], div_q[j-1].dvs);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_wz_q <= div_q[DivSteps-1].wz;
      out_data_q[127:96] <= div_q[DivSteps-1].wclip;
      for (int l = 0; l < 3; l++) begin
        out_data_q[CoordW*l +: CoordW] <= div_q[DivSteps-1].wz ? '0
          : quo_sat(div_q[DivSteps-1].lane[l].nq, div_q[DivSteps-1].neg[l]);
      end
    end
  end

  a_wz_zero_quot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |-> m_axis_tdata_o[95:0] == '0)
    else $error("zero w result with nonzero quotient");
  a_wz_zero_w: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |-> m_axis_tdata_o[127:96] == '0)
    else $error("zero w flag with nonzero clip w");
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o == (!m_axis_tvalid_o || m_axis_tready_i))
    else $error("input ready does not follow pipeline advance");
  a_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(vld_q))
    else $error("pipeline valid bits moved during a stall");

endmodule
`default_nettype wire

// ----- tb/sv/vtpd_checker.sv -----
// Checker for the vertex transform core: predicts each transfer's result and compares it.
`timescale 1ns / 1ps
module vtpd_checker (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid_i,
  input  wire logic         s_axis_tready_i,
  input  wire logic [127:0] s_axis_tdata_i,
  input  wire logic         m_axis_tvalid_i,
  input  wire logic         m_axis_tready_i,
  input  wire logic [127:0] m_axis_tdata_i,
  input  wire logic         m_axis_tuser_i,
  input  wire logic         cfg_we_i,
  input  wire logic [vtpd_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [vtpd_pkg::RowW-1:0]    cfg_data_i,
  output int                fail_count_o,
  output int                pending_o,
  output int                zero_w_seen_o
);

  logic [63:0]  mvp_rows [4];
  logic [128:0] ndc_queue [$];
  int           mismatches;
  int           zero_w_seen;

  assign fail_count_o  = mismatches;
  assign pending_o     = ndc_queue.size();
  assign zero_w_seen_o = zero_w_seen;

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Returns {w_zero, w_clip, z_ndc, y_ndc, x_ndc}.
  function automatic logic [128:0] project_vertex(logic [127:0] vtx);
    longint comp [4];
    longint clip [4];
    longint acc;
    longint weight;
    logic [127:0] res;
    for (int k = 0; k < 4; k++) comp[k] = longint'(signed'(vtx[32*k +: 32]));
    for (int i = 0; i < 4; i++) begin
      acc = 0;
      for (int k = 0; k < 4; k++) begin
        weight = longint'(signed'(mvp_rows[k][16*i +: 16]));
        acc += weight * comp[k];
      end
      // Arithmetic shift gives the floor, so this is round half up.
      clip[i] = clamp32((acc + 2048) >>> 12);
    end
    if (clip[3] == 0) return {1'b1, 128'd0};
    for (int i = 0; i < 3; i++) begin
      res[32*i +: 32] = 32'(clamp32((clip[i] * 65536) / clip[3]));
    end
    res[127:96] = 32'(clip[3]);
    return {1'b0, res};
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mvp_rows[0] <= vtpd_pkg::Row0Reset;
      mvp_rows[1] <= vtpd_pkg::Row1Reset;
      mvp_rows[2] <= vtpd_pkg::Row2Reset;
      mvp_rows[3] <= vtpd_pkg::Row3Reset;
      ndc_queue.delete();
      mismatches  <= 0;
      zero_w_seen <= 0;
    end else begin
      logic [128:0] want;
      logic [128:0] got;
      if (cfg_we_i) mvp_rows[cfg_idx_i] <= cfg_data_i;
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        ndc_queue = {ndc_queue, project_vertex(s_axis_tdata_i)};
      end
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got = {m_axis_tuser_i, m_axis_tdata_i};
        if (got[128]) zero_w_seen <= zero_w_seen + 1;
        if (ndc_queue.size() == 0) begin
          if (mismatches < 10) $display("unexpected result transfer %h", got);
          mismatches <= mismatches + 1;
        end else begin
          want = ndc_queue.pop_front();
          if (want !== got) begin
            if (mismatches < 10) begin
              $display("mismatch: x %h/%h y %h/%h z %h/%h w %h/%h wz %b/%b (exp/act)",
                       want[31:0], got[31:0], want[63:32], got[63:32],
                       want[95:64], got[95:64], want[127:96], got[127:96],
                       want[128], got[128]);
            end
            mismatches <= mismatches + 1;
          end
        end
      end
    end
  end

endmodule

// ----- tb/sv/testbench.sv -----
// Top of the vertex transform testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module testbench;

  localparam int CycleLimit = 600000;

  logic         clk_i;
  logic         rst_ni;
  logic         s_tvalid;
  logic         s_tready;
  logic [127:0] s_tdata;
  logic         m_tvalid;
  logic         m_tready;
  logic [127:0] m_tdata;
  logic         m_tuser;
  logic         cfg_we;
  logic [vtpd_pkg::CfgIdxW-1:0] cfg_idx;
  logic [vtpd_pkg::RowW-1:0]    cfg_data;
  int           fail_count;
  int           pending;
  int           zero_w_seen;
  int           cycles = 0;
  int           sent;
  bit           idle_on;
  bit           hold_req;

  vertex_transform_perspective_divide_core u_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid_i(s_tvalid), .s_axis_tready_o(s_tready), .s_axis_tdata_i(s_tdata),
    .m_axis_tvalid_o(m_tvalid), .m_axis_tready_i(m_tready), .m_axis_tdata_o(m_tdata),
    .m_axis_tuser_o(m_tuser),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data)
  );

  vtpd_checker u_checker (
    .clk_i, .rst_ni,
    .s_axis_tvalid_i(s_tvalid), .s_axis_tready_i(s_tready), .s_axis_tdata_i(s_tdata),
    .m_axis_tvalid_i(m_tvalid), .m_axis_tready_i(m_tready), .m_axis_tdata_i(m_tdata),
    .m_axis_tuser_i(m_tuser),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .fail_count_o(fail_count), .pending_o(pending), .zero_w_seen_o(zero_w_seen)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Receiver side: random stall bursts, plus one long hold-off on request.
  initial begin
    bit held;
    held = 1'b0;
    m_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req && !held) begin
        m_tready = 1'b0;
        repeat (400) @(negedge clk_i);
        held = 1'b1;
      end else if (idle_on && ($urandom % 3 == 0)) begin
        m_tready = 1'b0;
        repeat ($urandom_range(1, 14) - 1) @(negedge clk_i);
      end else begin
        m_tready = 1'b1;
        repeat ($urandom_range(1, 20) - 1) @(negedge clk_i);
      end
    end
  end

  function automatic logic [31:0] rand_coord();
    logic [31:0] v;
    case ($urandom % 6)
      0: v = $urandom;
      1: v = 32'h7fff_ffff;
      2: v = 32'h8000_0000;
      default: begin
        v = $urandom_range(0, 32'h0040_0000);
        if ($urandom % 2) v = -v;
      end
    endcase
    return v;
  endfunction

  function automatic logic [15:0] rand_weight();
    case ($urandom % 5)
      0: return 16'($urandom);
      1: return 16'h7fff;
      2: return 16'h8000;
      default: return 16'($urandom_range(0, 32'h2000) - 32'h1000);
    endcase
  endfunction

  // One transfer; the valid is raised at a falling edge and held until accepted.
  task automatic send_vertex(logic [31:0] x, logic [31:0] y, logic [31:0] z, logic [31:0] w);
    if (idle_on && ($urandom % 4 == 0)) begin
      s_tvalid = 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk_i);
    end
    s_tvalid = 1'b1;
    s_tdata  = {w, z, y, x};
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    sent++;
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    s_tvalid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (60) @(negedge clk_i);
  endtask

  task automatic write_row(int idx, logic [63:0] row);
    cfg_we   = 1'b1;
    cfg_idx  = idx[vtpd_pkg::CfgIdxW-1:0];
    cfg_data = row;
    @(negedge clk_i);
    cfg_we   = 1'b0;
    @(negedge clk_i);
  endtask

  initial begin
    logic [63:0] row;
    sent     = 0;
    idle_on  = 1'b1;
    hold_req = 1'b0;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    cfg_we   = 1'b0;
    cfg_idx  = '0;
    cfg_data = '0;
    rst_ni   = 1'b0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed vertices under the reset identity matrix.
    send_vertex(0, 0, 0, 0);
    send_vertex(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'h0001_0000);
    send_vertex(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    send_vertex(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_vertex(32'h7fff_ffff, 32'h8000_0000, 32'h0000_0001, 32'h0000_0001);
    send_vertex(32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    send_vertex(32'h1234_5678, 32'hedcb_a987, 32'h0, 32'h0);
    send_vertex(32'hffff_ffff, 32'h0000_0001, 32'h0000_8000, 32'hffff_0000);
    send_vertex(32'h0000_0800, 32'hffff_f800, 32'h0000_07ff, 32'h0000_0002);
    wait_drained();

    for (int phase = 1; phase < 11; phase++) begin
      for (int k = 0; k < 4; k++) begin
        case (phase)
          1: row = 64'h7fff_7fff_7fff_7fff;
          2: row = 64'h8000_8000_8000_8000;
          3: row = 64'h0;
          4: row = {16'h0, {3{rand_weight()}}};
          default: row = {rand_weight(), rand_weight(), rand_weight(), rand_weight()};
        endcase
        write_row(k, row);
      end
      if (phase == 1) begin
        send_vertex(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        send_vertex(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_vertex(32'h0000_0001, 32'h0, 32'h0, 32'hffff_ffff);
      end
      if (phase == 10) idle_on = 1'b0;
      for (int n = 0; n < 150; n++) begin
        if (phase == 5 && n == 10) hold_req = 1'b1;
        if ($urandom % 16 == 0) send_vertex(rand_coord(), rand_coord(), rand_coord(), 0);
        else send_vertex(rand_coord(), rand_coord(), rand_coord(), rand_coord());
      end
      wait_drained();
    end

    $display("Covered %0d vertices across 11 matrix settings (identity, extremes, zero, random).",
             sent);
    $display("Zero clip w results seen: %0d; random stalls on both sides and one long hold-off.",
             zero_w_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
sv/vtpd_pkg.sv
sv/vertex_transform_perspective_divide_core.sv
tb/sv/vtpd_checker.sv
tb/sv/testbench.sv
